FILE: hdl/mrop_pkg.sv
// ----------------------------------------------------------------------------
// mrop_pkg
// Shared types, codes and defaults of the matrix row operation engine.
// ----------------------------------------------------------------------------
package mrop_pkg;

   localparam int MAX_DIM_DEFAULT   = 16;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam int OP_W       = 3;
   localparam int IDX_W      = 5;
   localparam int DATA_W     = 32;
   localparam int CFG_W      = 5;
   localparam int CSR_ADDR_W = 4;

   // operation codes
   localparam logic [OP_W-1:0] OP_WRITE_ELEM = 3'd0;
   localparam logic [OP_W-1:0] OP_READ_ELEM  = 3'd1;
   localparam logic [OP_W-1:0] OP_SWAP_ROWS  = 3'd2;
   localparam logic [OP_W-1:0] OP_SCALE_ROW  = 3'd3;
   localparam logic [OP_W-1:0] OP_SUB_ROW    = 3'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] CSR_ROWS_IN_USE = 4'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_COLS_IN_USE = 4'd1;

   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic [IDX_W-1:0]         first_row;
      logic [IDX_W-1:0]         second_index;
      logic signed [DATA_W-1:0] value;
   } req_payload_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] read_data;
      logic                     index_error;
      logic                     saturated;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_ADDR_W-1:0] index;
      logic [DATA_W-1:0]     wdata;
   } csr_payload_type;

   // control of the fixed-point unit
   typedef struct packed {
      logic load;      // capture a product this cycle
      logic subtract;  // row subtract rather than row scale
   } fx_ctrl_type;

endpackage

FILE: hdl/mrop_stream_if.sv
// ----------------------------------------------------------------------------
// mrop_stream_if
// Valid/ready channel carrying one payload per request.
// ----------------------------------------------------------------------------
interface mrop_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/mrop_fx_unit.sv
// ----------------------------------------------------------------------------
// mrop_fx_unit
// Registered Q-format multiply, floor shift, optional subtract, saturation.
// ----------------------------------------------------------------------------
module mrop_fx_unit #(
   parameter int FRAC_BITS = mrop_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  mrop_pkg::fx_ctrl_type       ctrl,
   input  logic signed [31:0]          operand,
   input  logic signed [31:0]          multiplier,
   input  logic signed [31:0]          dst,
   output logic signed [31:0]          result,
   output logic                        clipped
);
   import mrop_pkg::*;

   logic signed [63:0] prod_in;
   logic signed [63:0] prod_ff;
   logic               sub_ff;
   logic signed [63:0] quot;
   logic signed [63:0] diff;
   logic               in_range;

   assign prod_in = operand * multiplier;

   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         prod_ff <= prod_in;
         sub_ff  <= ctrl.subtract;
      end
   end

   // arithmetic shift drops low bits: floor toward minus infinity
   assign quot = prod_ff >>> FRAC_BITS;
   assign diff = sub_ff ? ({{32{dst[31]}}, dst} - quot) : quot;

   assign in_range = (&diff[63:31]) | ~(|diff[63:31]);
   assign result   = in_range ? diff[31:0]
                              : (diff[63] ? 32'sh8000_0000 : 32'sh7fff_ffff);
   assign clipped  = ~in_range;

endmodule

FILE: hdl/matrix_row_operation_engine.sv
// ----------------------------------------------------------------------------
// matrix_row_operation_engine
// Matrix of signed fixed-point elements with elementary row operations.
// ----------------------------------------------------------------------------
// One request at a time, one response per request. After reset the element
// store is swept to zero, one entry per cycle, over all of its entries (256
// at the default of 16); no request is taken during the sweep, register
// writes are. An element write passes through WRITE to FINISH, a read
// through READ and READ_WAIT to FINISH; an error, an unused op, or a scale
// or subtract with no columns in use goes straight to FINISH. Row ops
// walk the row through the single-port-read element store (two reads per
// column, the write overlapping the next column's reads): scale and
// subtract walk cols_in_use columns (capped at MAX_DIM), swap all MAX_DIM
// columns. A new request is accepted once the engine is idle, even while
// the previous response waits.
// ----------------------------------------------------------------------------
module matrix_row_operation_engine #(
   parameter int MAX_DIM   = mrop_pkg::MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = mrop_pkg::FRAC_BITS_DEFAULT
) (
   input  logic           clock,
   input  logic           reset,
   mrop_stream_if.sink    req_if,
   mrop_stream_if.source  rsp_if,
   mrop_stream_if.sink    csr_if
);
   import mrop_pkg::*;

   localparam int RW     = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int AW     = 2 * RW;
   localparam int DEPTH  = 1 << AW;
   localparam int CNT_W  = $clog2(MAX_DIM + 1);
   localparam int EXT_W  = (RW > IDX_W) ? RW : IDX_W;

   localparam logic [2:0] ST_CLEAR     = 3'd0;
   localparam logic [2:0] ST_IDLE      = 3'd1;
   localparam logic [2:0] ST_WRITE     = 3'd2;
   localparam logic [2:0] ST_READ      = 3'd3;
   localparam logic [2:0] ST_READ_WAIT = 3'd4;
   localparam logic [2:0] ST_RUN       = 3'd5;
   localparam logic [2:0] ST_FINISH    = 3'd6;

   // 1-based index to 0-based row/column address
   function automatic logic [RW-1:0] to_addr(input logic [IDX_W-1:0] ix);
      logic [EXT_W-1:0] tmp;
      tmp = EXT_W'(ix) - EXT_W'(1);
      return tmp[RW-1:0];
   endfunction

   // configuration
   logic [CFG_W-1:0] rows_ff, cols_ff;
   logic [CNT_W-1:0] eff_rows, eff_cols;

   // control
   logic [2:0]       state_ff, state_in;
   logic [AW-1:0]    clr_ff, clr_in;
   logic             issue_ff, issue_in;
   logic             ph_ff, ph_in;
   logic [CNT_W-1:0] ci_ff, ci_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             s1_v_ff, s1_ph_ff, s2_v_ff;
   logic [RW-1:0]    s1_col_ff, s2_col_ff;
   logic             rsp_valid_ff, rsp_valid_in;

   // request payload and result
   logic [OP_W-1:0]    op_ff, op_in;
   logic [RW-1:0]      r1_ff, r1_in, r2_ff, r2_in, col_ff, col_in;
   logic signed [31:0] val_ff, val_in;
   logic signed [31:0] rd_ff, rd_in;
   logic               err_ff, err_in, clip_ff, clip_in;
   rsp_payload_type    rsp_data_ff, rsp_data_in;

   // element store
   logic [31:0]        store_ff [DEPTH];
   logic [31:0]        rdata_ff;
   logic [AW-1:0]      raddr, waddr;
   logic [31:0]        wdata;
   logic               we;

   // column datapath
   logic signed [31:0] a_ff, hold_ff;
   fx_ctrl_type        fx_ctrl;
   logic signed [31:0] fx_result;
   logic               fx_clip;

   // request decode
   req_payload_type    req;
   logic               r1_ok, r2_ok, c_ok, req_err, req_known;

   assign eff_rows = (int'(rows_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(rows_ff);
   assign eff_cols = (int'(cols_ff) > MAX_DIM) ? CNT_W'(MAX_DIM) : CNT_W'(cols_ff);

   assign req   = req_if.data;
   assign r1_ok = (req.first_row != '0) && (int'(req.first_row) <= int'(eff_rows));
   assign r2_ok = (req.second_index != '0) && (int'(req.second_index) <= int'(eff_rows));
   assign c_ok  = (req.second_index != '0) && (int'(req.second_index) <= int'(eff_cols));

   always_comb begin
      req_known = 1'b1;
      unique case (req.op)
         OP_WRITE_ELEM, OP_READ_ELEM: req_err = !(r1_ok && c_ok);
         OP_SWAP_ROWS, OP_SUB_ROW:    req_err = !(r1_ok && r2_ok);
         OP_SCALE_ROW:                req_err = !r1_ok;
         default: begin
            req_err   = 1'b0;
            req_known = 1'b0;
         end
      endcase
   end

   assign req_if.ready = (state_ff == ST_IDLE);
   assign csr_if.ready = 1'b1;
   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.data  = rsp_data_ff;

   // sequencer
   always_comb begin
      state_in     = state_ff;
      clr_in       = clr_ff;
      issue_in     = issue_ff;
      ph_in        = ph_ff;
      ci_in        = ci_ff;
      count_in     = count_ff;
      op_in        = op_ff;
      r1_in        = r1_ff;
      r2_in        = r2_ff;
      col_in       = col_ff;
      val_in       = val_ff;
      rd_in        = rd_ff;
      err_in       = err_ff;
      clip_in      = clip_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_in = clr_ff + AW'(1);
            if (clr_ff == AW'(DEPTH - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_if.valid) begin
               op_in   = req.op;
               r1_in   = to_addr(req.first_row);
               // scale reads its own row twice so the column beat stays uniform
               r2_in   = (req.op == OP_SCALE_ROW) ? to_addr(req.first_row)
                                                  : to_addr(req.second_index);
               col_in  = to_addr(req.second_index);
               val_in  = req.value;
               rd_in   = '0;
               err_in  = req_err;
               clip_in = 1'b0;
               ph_in   = 1'b0;
               ci_in   = '0;
               count_in = (req.op == OP_SWAP_ROWS) ? CNT_W'(MAX_DIM) : eff_cols;
               if (req_err || !req_known) begin
                  state_in = ST_FINISH;
               end else if (req.op == OP_WRITE_ELEM) begin
                  state_in = ST_WRITE;
               end else if (req.op == OP_READ_ELEM) begin
                  state_in = ST_READ;
               end else if (req.op != OP_SWAP_ROWS && eff_cols == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_RUN;
                  issue_in = 1'b1;
               end
            end
         end
         ST_WRITE:     state_in = ST_FINISH;
         ST_READ:      state_in = ST_READ_WAIT;
         ST_READ_WAIT: begin
            rd_in    = rdata_ff;
            state_in = ST_FINISH;
         end
         ST_RUN: begin
            if (issue_ff) begin
               ph_in = ~ph_ff;
               if (ph_ff) begin
                  ci_in = ci_ff + CNT_W'(1);
                  if (ci_in == count_ff) issue_in = 1'b0;
               end
            end else if (!s1_v_ff && !s2_v_ff) begin
               state_in = ST_FINISH;
            end
            if (s2_v_ff && op_ff != OP_SWAP_ROWS && fx_clip) clip_in = 1'b1;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.read_data   = rd_ff;
               rsp_data_in.index_error = err_ff;
               rsp_data_in.saturated   = clip_ff;
               state_in                = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         issue_ff     <= 1'b0;
         s1_v_ff      <= 1'b0;
         s2_v_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rows_ff      <= CFG_W'(3);
         cols_ff      <= CFG_W'(3);
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         issue_ff     <= issue_in;
         s1_v_ff      <= (state_ff == ST_RUN) && issue_ff;
         s2_v_ff      <= s1_v_ff && s1_ph_ff;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_if.valid) begin
            if (csr_if.data.index == CSR_ROWS_IN_USE) rows_ff <= csr_if.data.wdata[CFG_W-1:0];
            if (csr_if.data.index == CSR_COLS_IN_USE) cols_ff <= csr_if.data.wdata[CFG_W-1:0];
         end
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      ph_ff       <= ph_in;
      ci_ff       <= ci_in;
      count_ff    <= count_in;
      op_ff       <= op_in;
      r1_ff       <= r1_in;
      r2_ff       <= r2_in;
      col_ff      <= col_in;
      val_ff      <= val_in;
      rd_ff       <= rd_in;
      err_ff      <= err_in;
      clip_ff     <= clip_in;
      rsp_data_ff <= rsp_data_in;
      s1_ph_ff    <= ph_ff;
      s1_col_ff   <= ci_ff[RW-1:0];
      s2_col_ff   <= s1_col_ff;
      // first read of a column: target row element
      if (s1_v_ff && !s1_ph_ff) a_ff <= rdata_ff;
      if (s1_v_ff && s1_ph_ff) hold_ff <= a_ff;
   end

   // column beat: ph 0 reads the target row, ph 1 the source row
   always_comb begin
      if (state_ff == ST_RUN) begin
         raddr = ph_ff ? {r2_ff, ci_ff[RW-1:0]} : {r1_ff, ci_ff[RW-1:0]};
      end else begin
         raddr = {r1_ff, col_ff};
      end
   end

   // one write a cycle: sweep, element write, or the two row-op write slots
   always_comb begin
      we    = 1'b0;
      waddr = '0;
      wdata = '0;
      priority if (state_ff == ST_CLEAR) begin
         we    = 1'b1;
         waddr = clr_ff;
      end else if (state_ff == ST_WRITE) begin
         we    = 1'b1;
         waddr = {r1_ff, col_ff};
         wdata = val_ff;
      end else if (s2_v_ff) begin
         we = 1'b1;
         if (op_ff == OP_SWAP_ROWS) begin
            waddr = {r2_ff, s2_col_ff};
            wdata = hold_ff;
         end else begin
            waddr = {r1_ff, s2_col_ff};
            wdata = fx_result;
         end
      end else if (s1_v_ff && s1_ph_ff && op_ff == OP_SWAP_ROWS) begin
         we    = 1'b1;
         waddr = {r1_ff, s1_col_ff};
         wdata = rdata_ff;
      end else begin
         we = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (we) store_ff[waddr] <= wdata;
      rdata_ff <= store_ff[raddr];
   end

   assign fx_ctrl.load     = s1_v_ff && s1_ph_ff;
   assign fx_ctrl.subtract = (op_ff == OP_SUB_ROW);

   mrop_fx_unit #(
      .FRAC_BITS (FRAC_BITS)
   ) u_fx (
      .clock      (clock),
      .ctrl       (fx_ctrl),
      .operand    (rdata_ff),
      .multiplier (val_ff),
      .dst        (hold_ff),
      .result     (fx_result),
      .clipped    (fx_clip)
   );

endmodule

FILE: tb/mrop_checker.sv
// ----------------------------------------------------------------------------
// mrop_checker
// Tracks the element store and dimension registers of the matrix row
// operation engine from the handshakes it sees on the request, response and
// register channels, predicts every response in order, and compares each
// accepted response field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module mrop_checker
   import mrop_pkg::*;
#(
   parameter int MAX_DIM   = MAX_DIM_DEFAULT,
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_data,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_data,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_payload_type csr_data,
   output int              mismatches,
   output int              outstanding
);

   localparam logic [CFG_W-1:0] DIM_RESET = CFG_W'(3);

   logic signed [DATA_W-1:0] elem [MAX_DIM][MAX_DIM];
   logic [CFG_W-1:0]         rows_reg;
   logic [CFG_W-1:0]         cols_reg;
   rsp_payload_type          awaited [$];
   int                       fail_count = 0;
   int                       rsp_number = 0;

   // floor(x * a / 2**FRAC_BITS), exact in 64 bits
   function automatic logic signed [63:0] fx_product(input logic signed [DATA_W-1:0] x,
                                                     input logic signed [DATA_W-1:0] a);
      logic signed [63:0] xe;
      logic signed [63:0] ae;
      xe = x;
      ae = a;
      return (xe * ae) >>> FRAC_BITS;
   endfunction

   // {clipped, value} clamped to the 32-bit signed range
   function automatic logic [DATA_W:0] clip32(input logic signed [63:0] v);
      if (v > 64'sd2147483647)
         return {1'b1, 32'h7FFF_FFFF};
      if (v < -64'sd2147483648)
         return {1'b1, 32'h8000_0000};
      return {1'b0, v[DATA_W-1:0]};
   endfunction

   function automatic rsp_payload_type row_engine_step(input req_payload_type rq);
      rsp_payload_type          res;
      int                       nr;
      int                       nc;
      int                       r1;
      int                       ix2;
      logic                     row_ok;
      logic                     src_ok;
      logic                     col_ok;
      logic [DATA_W:0]          c;
      logic signed [63:0]       x64;
      logic signed [DATA_W-1:0] t;
      nr     = (rows_reg > MAX_DIM) ? MAX_DIM : int'(rows_reg);
      nc     = (cols_reg > MAX_DIM) ? MAX_DIM : int'(cols_reg);
      r1     = rq.first_row;
      ix2    = rq.second_index;
      row_ok = (r1 >= 1) && (r1 <= nr);
      src_ok = (ix2 >= 1) && (ix2 <= nr);
      col_ok = (ix2 >= 1) && (ix2 <= nc);
      res    = '0;
      case (rq.op)
         OP_WRITE_ELEM, OP_READ_ELEM: begin
            if (!row_ok || !col_ok)
               res.index_error = 1'b1;
            else if (rq.op == OP_WRITE_ELEM)
               elem[r1-1][ix2-1] = rq.value;
            else
               res.read_data = elem[r1-1][ix2-1];
         end
         OP_SWAP_ROWS: begin
            if (!row_ok || !src_ok) begin
               res.index_error = 1'b1;
            end else begin
               // swap covers the full row, not just the columns in use
               for (int k = 0; k < MAX_DIM; k++) begin
                  t                = elem[r1-1][k];
                  elem[r1-1][k]  = elem[ix2-1][k];
                  elem[ix2-1][k] = t;
               end
            end
         end
         OP_SCALE_ROW: begin
            if (!row_ok) begin
               res.index_error = 1'b1;
            end else begin
               for (int k = 0; k < nc; k++) begin
                  c               = clip32(fx_product(elem[r1-1][k], rq.value));
                  elem[r1-1][k] = c[DATA_W-1:0];
                  res.saturated   = res.saturated | c[DATA_W];
               end
            end
         end
         OP_SUB_ROW: begin
            if (!row_ok || !src_ok) begin
               res.index_error = 1'b1;
            end else begin
               for (int k = 0; k < nc; k++) begin
                  // source read before target write: self-subtract works per element
                  x64             = elem[r1-1][k];
                  c               = clip32(x64 - fx_product(elem[ix2-1][k], rq.value));
                  elem[r1-1][k] = c[DATA_W-1:0];
                  res.saturated   = res.saturated | c[DATA_W];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   task automatic note_mismatch(input string what);
      fail_count++;
      if (fail_count <= 10)
         $display("[%0t] checker: %s", $realtime, what);
   endtask

   always @(posedge clock) begin
      rsp_payload_type exp_rsp;
      if (reset) begin
         rows_reg = DIM_RESET;
         cols_reg = DIM_RESET;
         awaited.delete();
         for (int r = 0; r < MAX_DIM; r++)
            for (int k = 0; k < MAX_DIM; k++)
               elem[r][k] = '0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_data.index == CSR_ROWS_IN_USE)
               rows_reg = csr_data.wdata[CFG_W-1:0];
            else if (csr_data.index == CSR_COLS_IN_USE)
               cols_reg = csr_data.wdata[CFG_W-1:0];
         end
         // pop before push: a response never belongs to a same-edge request
         if (rsp_valid && rsp_ready) begin
            rsp_number++;
            if (awaited.size() == 0) begin
               note_mismatch($sformatf("response %0d with no request pending: data %h err %b sat %b",
                                       rsp_number, rsp_data.read_data, rsp_data.index_error,
                                       rsp_data.saturated));
            end else begin
               exp_rsp = awaited.pop_front();
               if (rsp_data.read_data   !== exp_rsp.read_data   ||
                   rsp_data.index_error !== exp_rsp.index_error ||
                   rsp_data.saturated   !== exp_rsp.saturated)
                  note_mismatch($sformatf(
                     "response %0d: expected data %h err %b sat %b, got data %h err %b sat %b",
                     rsp_number, exp_rsp.read_data, exp_rsp.index_error, exp_rsp.saturated,
                     rsp_data.read_data, rsp_data.index_error, rsp_data.saturated));
            end
         end
         if (req_valid && req_ready)
            awaited.push_back(row_engine_step(req_data));
      end
      mismatches  <= fail_count;
      outstanding <= awaited.size();
   end

endmodule

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the matrix row operation engine.
// ----------------------------------------------------------------------------
// A short directed sequence at the reset dimensions hits value extremes,
// saturation both ways, self-subtract, swap and every index error, then
// random phases run under a range of dimension settings (zero, one, full,
// above the maximum and odd shapes). A separate checker predicts and
// compares; this module only drives the channels and decides the verdict.
// ----------------------------------------------------------------------------
module tb_top;
   import mrop_pkg::*;

   // the hold-off on the response side is the longest legitimate quiet stretch
   localparam int STALL_LIMIT     = 4000;
   localparam int TAIL_CYCLES     = 60;
   localparam int HOLD_OFF_AT     = 400;   // response count that starts the hold-off
   localparam int HOLD_OFF_CYCLES = 300;

   localparam logic [OP_W-1:0]          OP_LAST = OP_SUB_ROW;  // ops above are no-ops
   localparam logic signed [DATA_W-1:0] Q_MAX   = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] Q_MIN   = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] Q_ONE   = 32'sh0001_0000;
   localparam logic signed [DATA_W-1:0] Q_TWO   = 32'sh0002_0000;
   localparam logic signed [DATA_W-1:0] Q_M1P5  = 32'shFFFE_8000;  // -1.5
   localparam logic signed [DATA_W-1:0] Q_LSB   = 32'sh0000_0001;

   logic clock;
   logic reset;

   mrop_stream_if #(.payload_type(req_payload_type)) req_ch ();
   mrop_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   mrop_stream_if #(.payload_type(csr_payload_type)) csr_ch ();

   int mismatches;
   int outstanding;
   int eff_rows;        // effective dimensions the stimulus aims at
   int eff_cols;
   bit steady = 1'b0;   // no idling on either side while set
   int quiet_cycles = 0;

   matrix_row_operation_engine dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch),
      .csr_if (csr_ch)
   );

   mrop_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_ch.valid),
      .req_ready   (req_ch.ready),
      .req_data    (req_ch.data),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_data    (rsp_ch.data),
      .csr_valid   (csr_ch.valid),
      .csr_ready   (csr_ch.ready),
      .csr_data    (csr_ch.data),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Watchdog: ends the run when no channel moves for too long
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == STALL_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Response side: random back-pressure, plus one long hold-off so the
   // engine takes one more request and then stalls its input
   // ---------------------------------------------------------------------
   initial begin
      int  rsp_taken;
      bit  held_off;
      rsp_taken = 0;
      held_off  = 1'b0;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            rsp_taken++;
         if (!held_off && rsp_taken == HOLD_OFF_AT) begin
            held_off = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= steady || ($urandom_range(99) >= 10);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Request builders
   // ---------------------------------------------------------------------
   function automatic req_payload_type make_request(input logic [OP_W-1:0] op,
                                                    input int row, input int idx,
                                                    input logic signed [DATA_W-1:0] value);
      req_payload_type rq;
      rq.op           = op;
      rq.first_row    = IDX_W'(row);
      rq.second_index = IDX_W'(idx);
      rq.value        = value;
      return rq;
   endfunction

   function automatic logic signed [DATA_W-1:0] extreme_value();
      case ($urandom_range(6))
         0:       return Q_MAX;
         1:       return Q_MIN;
         2:       return '0;
         3:       return Q_LSB;
         4:       return -Q_LSB;
         5:       return Q_ONE;
         default: return -Q_ONE;
      endcase
   endfunction

   // mostly in range; about one in eight anywhere in the 5-bit field
   function automatic int pick_index(input int limit);
      if (limit == 0 || $urandom_range(99) < 12)
         return $urandom_range(31);
      return $urandom_range(limit, 1);
   endfunction

   // element values: mostly within +-8.0 so row ops stay meaningful
   function automatic logic signed [DATA_W-1:0] pick_element();
      int roll;
      roll = $urandom_range(99);
      if (roll < 55)
         return int'($urandom_range(32'h10_0000)) - 32'sh8_0000;
      if (roll < 80)
         return $urandom();
      return extreme_value();
   endfunction

   // multipliers: small, near one, anything, or an extreme
   function automatic logic signed [DATA_W-1:0] pick_multiplier();
      int roll;
      roll = $urandom_range(99);
      if (roll < 45)
         return int'($urandom_range(32'h4_0000)) - 32'sh2_0000;
      if (roll < 60)
         return Q_ONE + int'($urandom_range(512)) - 256;
      if (roll < 85)
         return $urandom();
      return extreme_value();
   endfunction

   function automatic req_payload_type pick_request();
      logic [OP_W-1:0] op;
      int              roll;
      int              idx;
      roll = $urandom_range(99);
      if (roll < 28)
         op = OP_WRITE_ELEM;
      else if (roll < 52)
         op = OP_READ_ELEM;
      else if (roll < 62)
         op = OP_SWAP_ROWS;
      else if (roll < 78)
         op = OP_SCALE_ROW;
      else if (roll < 95)
         op = OP_SUB_ROW;
      else
         op = OP_LAST + OP_W'($urandom_range(3, 1));
      // element ops index a column, row ops a source row
      if (op == OP_WRITE_ELEM || op == OP_READ_ELEM)
         idx = pick_index(eff_cols);
      else
         idx = pick_index(eff_rows);
      if (op == OP_WRITE_ELEM)
         return make_request(op, pick_index(eff_rows), idx, pick_element());
      if (op == OP_SCALE_ROW || op == OP_SUB_ROW)
         return make_request(op, pick_index(eff_rows), idx, pick_multiplier());
      return make_request(op, pick_index(eff_rows), idx, $urandom());
   endfunction

   // ---------------------------------------------------------------------
   // Channel drivers
   // ---------------------------------------------------------------------
   // Returns at the edge where the request was taken, valid still high;
   // the next call or the caller lowers it.
   task automatic offer(input req_payload_type rq);
      while (!steady && $urandom_range(99) < 10) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= rq;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
   endtask

   // Leaves valid high; the caller lowers it after the last write.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] idx, input int dim);
      csr_payload_type wr;
      wr.index                 = idx;
      wr.wdata                 = $urandom();   // upper bits are don't-care noise
      wr.wdata[CFG_W-1:0]      = CFG_W'(dim);
      csr_ch.valid <= 1'b1;
      csr_ch.data  <= wr;
      @(posedge clock);
      while (!csr_ch.ready)
         @(posedge clock);
   endtask

   // Stop offering and wait until every response is back. The first edge
   // lets the checker's count catch up with a request taken just now.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
   endtask

   // Engine is idle here, so the dimension registers may change
   task automatic run_phase(input int rows, input int cols, input int count, input bit quiet);
      drain();
      write_reg(CSR_ROWS_IN_USE, rows);
      write_reg(CSR_COLS_IN_USE, cols);
      csr_ch.valid <= 1'b0;
      eff_rows = (rows > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : rows;
      eff_cols = (cols > MAX_DIM_DEFAULT) ? MAX_DIM_DEFAULT : cols;
      steady   = quiet;
      repeat (count)
         offer(pick_request());
      steady   = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------
   initial begin
      req_ch.valid <= 1'b0;
      req_ch.data  <= '0;
      csr_ch.valid <= 1'b0;
      csr_ch.data  <= '0;
      reset        <= 1'b1;
      eff_rows     = 3;
      eff_cols     = 3;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed, at the reset shape of 3 x 3
      offer(make_request(OP_WRITE_ELEM, 1, 1, Q_MAX));
      offer(make_request(OP_WRITE_ELEM, 1, 2, Q_MIN));
      offer(make_request(OP_WRITE_ELEM, 1, 3, Q_TWO));
      offer(make_request(OP_READ_ELEM, 1, 1, '0));
      offer(make_request(OP_READ_ELEM, 1, 2, '0));
      // doubling clips both extremes; column index is ignored by scale
      offer(make_request(OP_SCALE_ROW, 1, 31, Q_TWO));
      offer(make_request(OP_READ_ELEM, 1, 3, '0));
      offer(make_request(OP_WRITE_ELEM, 2, 1, Q_M1P5));
      offer(make_request(OP_WRITE_ELEM, 2, 3, -Q_LSB));
      // row minus itself times the most negative multiplier
      offer(make_request(OP_SUB_ROW, 2, 2, Q_MIN));
      offer(make_request(OP_READ_ELEM, 2, 1, '0));
      offer(make_request(OP_SUB_ROW, 3, 1, Q_MAX));
      offer(make_request(OP_SWAP_ROWS, 1, 3, '0));
      offer(make_request(OP_READ_ELEM, 3, 1, '0));
      offer(make_request(OP_SCALE_ROW, 2, 0, -Q_ONE));
      // index errors: zero, past the rows, past the columns, all-ones field
      offer(make_request(OP_WRITE_ELEM, 0, 1, Q_ONE));
      offer(make_request(OP_READ_ELEM, 1, 0, '0));
      offer(make_request(OP_READ_ELEM, 4, 3, '0));
      offer(make_request(OP_READ_ELEM, 3, 4, '0));
      offer(make_request(OP_SWAP_ROWS, 1, 4, '0));
      offer(make_request(OP_SCALE_ROW, 0, 1, Q_ONE));
      offer(make_request(OP_SUB_ROW, 3, 31, Q_ONE));
      offer(make_request(OP_READ_ELEM, 31, 31, Q_MAX));
      // unused opcodes do nothing
      offer(make_request(OP_LAST + 3'd1, 1, 1, Q_MIN));
      offer(make_request(OP_LAST + 3'd3, 31, 31, Q_MAX));

      // random phases over a spread of shapes; one runs with no idling
      run_phase(16, 16, 400, 1'b0);
      run_phase(1, 1, 60, 1'b0);
      run_phase(31, 20, 250, 1'b1);   // above the maximum: capped at 16
      run_phase(0, 0, 30, 1'b0);      // no index valid at all
      run_phase(5, 9, 300, 1'b0);
      run_phase(16, 2, 200, 1'b0);
      run_phase(2, 16, 200, 1'b0);
      run_phase(7, 4, 300, 1'b0);

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
